### rtl/core/lgwr_pkg.sv
// ----------------------------------------------------------------------------
// lgwr_pkg: shared types and constants of the water ripple block
// Grid geometry, key-to-cell table, command and status structures.
// ----------------------------------------------------------------------------
package lgwr_pkg;

  localparam int unsigned GridWidth  = 14;
  localparam int unsigned GridHeight = 5;
  localparam int unsigned KeyColumns = 16;
  localparam int unsigned KeyRows    = 4;
  localparam int unsigned CellCount  = GridWidth * GridHeight;
  localparam int unsigned KeyCount   = KeyColumns * KeyRows;
  localparam int unsigned CellW      = $clog2(CellCount);
  localparam int unsigned KeyW       = $clog2(KeyCount);
  localparam int unsigned XW         = $clog2(GridWidth);
  localparam int unsigned YW         = $clog2(GridHeight);

  localparam logic [7:0]  DropPeak   = 8'h7f;
  localparam logic [7:0]  DropRing   = 8'h50;
  localparam logic [15:0] IdleReset  = 16'd5000;

  localparam logic OpKey  = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef logic [CellW-1:0] cell_t;

  function automatic cell_t key_to_cell(input logic [KeyW-1:0] k);
    cell_t c;
    unique case (k)
      6'd7:  c = cell_t'(59);
      6'd8:  c = cell_t'(66);
      6'd22: c = cell_t'(34);
      6'd23: c = cell_t'(60);
      6'd24: c = cell_t'(65);
      6'd25: c = cell_t'(35);
      6'd38: c = cell_t'(48);
      6'd39: c = cell_t'(61);
      6'd40: c = cell_t'(64);
      6'd41: c = cell_t'(49);
      6'd54: c = cell_t'(58);
      6'd55: c = cell_t'(62);
      6'd56: c = cell_t'(63);
      6'd57: c = cell_t'(67);
      default: begin
        if (k < 6'd7) c = cell_t'(k);
        else if (k < 6'd16) c = cell_t'(k - 6'd2);
        else if (k < 6'd22) c = cell_t'(k - 6'd2);
        else if (k < 6'd32) c = cell_t'(k - 6'd4);
        else if (k < 6'd38) c = cell_t'(k - 6'd4);
        else if (k < 6'd48) c = cell_t'(k - 6'd6);
        else if (k < 6'd54) c = cell_t'(k - 6'd6);
        else c = cell_t'(k - 6'd8);
      end
    endcase
    return c;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_en;      // write wr_val to page wr_page at wr_cell
    logic             wr_page;
    cell_t            wr_cell;
    logic [7:0]       wr_val;
    logic             rd_en;      // read rd_page at rd_cell
    logic             rd_page;
    cell_t            rd_cell;
    logic             acc_clr;    // start a new neighbour sum
    logic             acc_add;    // add the read data of the previous cycle
    logic             old_cap;    // capture the read data as the old value
  } lgwr_cmd_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic [7:0] ripple;
  } lgwr_sts_t;

endpackage

### rtl/core/lgwr_datapath.sv
// ----------------------------------------------------------------------------
// lgwr_datapath: height memory and ripple arithmetic
// Holds both pages in one memory and forms the ripple value of one cell.
// ----------------------------------------------------------------------------
module lgwr_datapath import lgwr_pkg::*; (
  input  logic      clk_i,
  input  lgwr_cmd_t cmd_i,
  output lgwr_sts_t sts_o
);

  logic [7:0]  mem_q [2][CellCount];
  logic [7:0]  rd_q;
  logic [10:0] acc_q;
  logic [7:0]  old_q;
  logic signed [10:0] v;
  logic signed [10:0] r;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_page][cmd_i.wr_cell] <= cmd_i.wr_val;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_page][cmd_i.rd_cell];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + {{3{rd_q[7]}}, rd_q};
    end
    if (cmd_i.old_cap) begin
      old_q <= rd_q;
    end
  end

  // Arithmetic shifts give the floor behaviour of the ripple rule.
  always_comb begin
    v = ($signed(acc_q) >>> 2) - $signed({{3{old_q[7]}}, old_q});
    r = v - (v >>> 3);
  end

  assign sts_o.rd_data = rd_q;
  assign sts_o.ripple  = r[7:0];

endmodule

### rtl/core/lgwr_ctrl.sv
// ----------------------------------------------------------------------------
// lgwr_ctrl: sequencer of the water ripple block
// Handles key events, idle rain, the ripple sweep and the height readout.
// ----------------------------------------------------------------------------
module lgwr_ctrl import lgwr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     quiet_period_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  logic [5:0]      key_index_i,
  input  logic            key_pressed_i,
  input  logic [3:0]      drop_x_i,
  input  logic [2:0]      drop_y_i,
  input  logic [5:0]      drop_gap_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [5:0]      key_slot_o,
  output logic signed [7:0] height_o,
  output logic [8:0]      intensity_o,
  output logic [7:0]      frame_hue_o,
  output logic            last_o,
  output lgwr_cmd_t       cmd_o,
  input  lgwr_sts_t       sts_i
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_RAIN  = 7'b0000100,
    S_RIP   = 7'b0001000,
    S_RD    = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_HOLD  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic        page_q, page_d;
  logic [7:0]  idle_q, idle_d;
  logic [5:0]  gap_q, gap_d;
  logic [7:0]  hue_q, hue_d;
  logic [7:0]  cnt_q, cnt_d;     // clear index, rain step or key slot
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [XW-1:0] rx_q, rx_d;
  logic [YW-1:0] ry_q, ry_d;
  logic [3:0]  ph_q, ph_d;       // ripple phase within one cell
  logic        ov_q, ov_d;
  logic [5:0]  oslot_q, oslot_d;
  logic [7:0]  oh_q, oh_d;
  logic [7:0]  ohue_q, ohue_d;

  logic [9:0]  base;
  logic [7:0]  idle_inc;
  logic [XW-1:0] xl, xr, nx, dx;
  logic [YW-1:0] yu, yd, ny, dy;
  logic [XW:0]  dxm;
  logic [YW:0]  dym;
  logic [7:0]  habs;

  assign base     = quiet_period_i[15:6];
  assign idle_inc = idle_q + 8'd1;
  assign xl = (x_q == '0) ? x_q : x_q - 1'b1;
  assign xr = (x_q == XW'(GridWidth - 1)) ? x_q : x_q + 1'b1;
  assign yu = (y_q == '0) ? y_q : y_q - 1'b1;
  assign yd = (y_q == YW'(GridHeight - 1)) ? y_q : y_q + 1'b1;
  assign dxm = {1'b0, drop_x_i} - (XW+1)'(GridWidth);
  assign dym = {1'b0, drop_y_i} - (YW+1)'(GridHeight);

  function automatic cell_t cell_of(input logic [XW-1:0] cx, input logic [YW-1:0] cy);
    return cell_t'(cy * GridWidth) + cell_t'(cx);
  endfunction

  always_comb begin
    dx = dxm[XW] ? drop_x_i : dxm[XW-1:0];
    dy = dym[YW] ? drop_y_i : dym[YW-1:0];
    unique case (ph_q)
      4'd0: begin nx = x_q; ny = yu; end
      4'd1: begin nx = x_q; ny = yd; end
      4'd2: begin nx = xl;  ny = y_q; end
      4'd3: begin nx = xr;  ny = y_q; end
      4'd4: begin nx = xl;  ny = yu; end
      4'd5: begin nx = xr;  ny = yu; end
      4'd6: begin nx = xl;  ny = yd; end
      default: begin nx = xr; ny = yd; end
    endcase
  end

  always_comb begin
    state_d = state_q; page_d = page_q; idle_d = idle_q; gap_d = gap_q;
    hue_d = hue_q; cnt_d = cnt_q; x_d = x_q; y_d = y_q; rx_d = rx_q;
    ry_d = ry_q; ph_d = ph_q; ov_d = ov_q; oslot_d = oslot_q; oh_d = oh_q;
    ohue_d = ohue_q;
    cmd_o = '0;
    in_stall_o = (state_q != S_IDLE);
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wr_page = cnt_q[7];
        cmd_o.wr_cell = cell_t'(cnt_q[6:0]);
        cnt_d = cnt_q + 8'd1;
        if (cnt_q[6:0] == 7'(CellCount - 1)) begin
          if (cnt_q[7]) state_d = S_IDLE;
          else cnt_d = 8'd128;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == OpKey) begin
            if (key_pressed_i) begin
              cmd_o.wr_en = 1'b1; cmd_o.wr_page = page_q;
              cmd_o.wr_cell = key_to_cell(key_index_i);
              cmd_o.wr_val = DropPeak;
              idle_d = '0;
            end
          end else begin
            hue_d = hue_q + 8'd1;
            idle_d = idle_inc;
            x_d = '0; y_d = '0; ph_d = '0; cnt_d = '0;
            state_d = S_RIP;
            if (quiet_period_i != '0 &&
                {3'b0, idle_inc} >= {5'b0, gap_q} + {1'b0, base}) begin
              gap_d = drop_gap_i; idle_d = base[7:0];
              rx_d = dx; ry_d = dy;
              state_d = S_RAIN;
            end
          end
        end
      end
      S_RAIN: begin
        cmd_o.wr_page = page_q;
        cmd_o.wr_val = DropRing;
        unique case (cnt_q[2:0])
          3'd0: begin
            cmd_o.wr_en = 1'b1; cmd_o.wr_val = DropPeak;
            cmd_o.wr_cell = cell_of(rx_q, ry_q);
          end
          3'd1: begin
            cmd_o.wr_en = (ry_q != '0);
            cmd_o.wr_cell = cell_of(rx_q, ry_q - 1'b1);
          end
          3'd2: begin
            cmd_o.wr_en = (ry_q != YW'(GridHeight - 1));
            cmd_o.wr_cell = cell_of(rx_q, ry_q + 1'b1);
          end
          3'd3: begin
            cmd_o.wr_en = (rx_q != '0);
            cmd_o.wr_cell = cell_of(rx_q - 1'b1, ry_q);
          end
          default: begin
            cmd_o.wr_en = (rx_q != XW'(GridWidth - 1));
            cmd_o.wr_cell = cell_of(rx_q + 1'b1, ry_q);
          end
        endcase
        cnt_d = cnt_q + 8'd1;
        if (cnt_q[2:0] == 3'd4) begin cnt_d = '0; state_d = S_RIP; end
      end
      S_RIP: begin
        // Phases 0..7 read neighbours, 8 reads the old value, 10 writes.
        cmd_o.rd_en = (ph_q <= 4'd8);
        cmd_o.rd_page = (ph_q == 4'd8) ? !page_q : page_q;
        cmd_o.rd_cell = (ph_q == 4'd8) ? cell_of(x_q, y_q) : cell_of(nx, ny);
        cmd_o.acc_clr = (ph_q == 4'd0);
        cmd_o.acc_add = (ph_q >= 4'd1 && ph_q <= 4'd8);
        cmd_o.old_cap = (ph_q == 4'd9);
        ph_d = ph_q + 4'd1;
        if (ph_q == 4'd10) begin
          cmd_o.wr_en = 1'b1; cmd_o.wr_page = !page_q;
          cmd_o.wr_cell = cell_of(x_q, y_q); cmd_o.wr_val = sts_i.ripple;
          ph_d = '0;
          if (x_q == XW'(GridWidth - 1)) begin
            x_d = '0;
            if (y_q == YW'(GridHeight - 1)) begin y_d = '0; state_d = S_RD; end
            else y_d = y_q + 1'b1;
          end else x_d = x_q + 1'b1;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_page = page_q;
        cmd_o.rd_cell = key_to_cell(cnt_q[5:0]);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1; oslot_d = cnt_q[5:0]; oh_d = sts_i.rd_data;
          ohue_d = hue_q;
          cnt_d = cnt_q + 8'd1;
          if (cnt_q[5:0] == 6'(KeyCount - 1)) state_d = S_HOLD;
          else state_d = S_RD;
        end
      end
      S_HOLD: begin
        page_d = !page_q; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; page_q <= 1'b0; idle_q <= '0; gap_q <= '0;
      hue_q <= '0; cnt_q <= '0; x_q <= '0; y_q <= '0; rx_q <= '0;
      ry_q <= '0; ph_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; page_q <= page_d; idle_q <= idle_d; gap_q <= gap_d;
      hue_q <= hue_d; cnt_q <= cnt_d; x_q <= x_d; y_q <= y_d; rx_q <= rx_d;
      ry_q <= ry_d; ph_q <= ph_d; ov_q <= ov_d;
    end
  end

  // The hue travels with each result, as a following tick may advance the
  // counter while the final key of a frame is still waiting.
  always_ff @(posedge clk_i) begin
    oslot_q <= oslot_d;
    oh_q <= oh_d;
    ohue_q <= ohue_d;
  end

  assign habs        = oh_q[7] ? 8'(-oh_q) : oh_q;
  assign out_valid_o = ov_q;
  assign key_slot_o  = oslot_q;
  assign height_o    = oh_q;
  assign intensity_o = (oh_q == 8'h80) ? 9'd256 : {habs, 1'b0};
  assign frame_hue_o = ohue_q;
  assign last_o      = (oslot_q == 6'(KeyCount - 1));

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_swap_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) |=> (page_q != $past(page_q))) else $error("page not swapped");
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q <= 4'd10) else $error("ripple phase out of range");

endmodule

### rtl/core/led_grid_water_ripple_top.sv
// ----------------------------------------------------------------------------
// led_grid_water_ripple_top: two-page water ripple on a 14x5 key grid
// Key presses splash, frame ticks rain, ripple and report 64 key heights.
// ----------------------------------------------------------------------------
// A key event is taken without stalling the input. A frame tick stalls the
// input while it walks the grid: rain first, when it falls, then the ripple
// sweep, which for each cell makes eight neighbour reads, one read of the old
// value, a capture and a write through the page store. Then it reads and
// reports each key height, waiting while the output is stalled, and swaps the
// pages before the next transaction is taken. After reset the block clears
// the 140-entry height store before it accepts its first item.
module led_grid_water_ripple_top import lgwr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [5:0]        key_index_i,
  input  logic              key_pressed_i,
  input  logic [3:0]        drop_x_i,
  input  logic [2:0]        drop_y_i,
  input  logic [5:0]        drop_gap_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [5:0]        key_slot_o,
  output logic signed [7:0] height_o,
  output logic [8:0]        intensity_o,
  output logic [7:0]        frame_hue_o,
  output logic              last_o
);

  logic [15:0] quiet_period_q;
  lgwr_cmd_t   cmd;
  lgwr_sts_t   sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) quiet_period_q <= IdleReset;
    else if (cfg_we_i) quiet_period_q <= cfg_wdata_i;
  end

  lgwr_ctrl u_ctrl (
    .clk_i, .rst_ni, .quiet_period_i(quiet_period_q),
    .in_valid_i, .in_stall_o, .operation_i, .key_index_i, .key_pressed_i,
    .drop_x_i, .drop_y_i, .drop_gap_i, .out_valid_o, .out_stall_i,
    .key_slot_o, .height_o, .intensity_o, .frame_hue_o, .last_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  lgwr_datapath u_dp (.clk_i, .cmd_i(cmd), .sts_o(sts));

endmodule
